### rtl/periodic_task_release_timer_core_assert.svh
// Assertion macros shared by the periodic task release timer RTL
`ifndef PERIODIC_TASK_RELEASE_TIMER_CORE_ASSERT_SVH
`define PERIODIC_TASK_RELEASE_TIMER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset
`define PTRT_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define PTRT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/ptrt_pkg.sv
// Types and codes of the periodic task release timer
package ptrt_pkg;

   typedef enum logic [1:0] {
      OP_REGISTER   = 2'd0,
      OP_UNREGISTER = 2'd1,
      OP_TIMER      = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      STAT_OK          = 2'd0,
      STAT_BOUNDS      = 2'd1,
      STAT_ZERO_PERIOD = 2'd2,
      STAT_BUSY        = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SCAN = 2'b10
   } state_type;

   localparam int TIME_W = 16;
   localparam int MASK_OUT_W = 8;

endpackage

### rtl/ptrt_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle
module ptrt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/periodic_task_release_timer_core.sv
// Periodic task release timer: task table, command decode and release scan
//
// Register, unregister and unused opcodes finish in the transfer cycle: the
// result strobes on the next cycle and busy stays low, so commands may follow
// one per cycle. A timer match scans the task table one slot per cycle through
// the registered read port of the release and period RAMs and a single shared
// adder, match comparator and minimum comparator: busy stays high for the whole
// scan, and the result strobes after the last slot is evaluated. rsp_strobe is
// high for exactly one cycle per transfer and cannot be held off; rsp_next_interrupt
// is the compare time after the item. No clearing pass follows reset.
`include "periodic_task_release_timer_core_assert.svh"

module periodic_task_release_timer_core #(
   parameter int TASK_SLOTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_slot_index,
   input  logic [15:0] req_phase_ticks,
   input  logic [15:0] req_period_ticks,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_next_interrupt,
   output logic [7:0]  rsp_released_mask
);

   localparam int IDX_W  = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int CNT_W  = IDX_W + 1;
   localparam int MASK_W = (TASK_SLOTS > ptrt_pkg::MASK_OUT_W) ? TASK_SLOTS
                                                               : ptrt_pkg::MASK_OUT_W;
   localparam int TW     = ptrt_pkg::TIME_W;
   localparam logic [CNT_W-1:0] SLOT_COUNT = CNT_W'(TASK_SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(TASK_SLOTS - 1);

   ptrt_pkg::state_type  state_ff, state_in;
   ptrt_pkg::opcode_type opcode;

   logic [TASK_SLOTS-1:0] valid_ff, valid_in;
   logic [TW-1:0]         irq_time_ff, irq_time_in;
   logic [CNT_W-1:0]      scan_idx_ff, scan_idx_in;
   logic                  eval_vld_ff, eval_vld_in;
   logic [IDX_W-1:0]      eval_idx_ff, eval_idx_in;
   logic [TW-1:0]         min_ff, min_in;
   logic                  any_ff, any_in;
   logic [MASK_W-1:0]     hit_mask_ff, hit_mask_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [7:0]            rsp_mask_ff, rsp_mask_in;

   logic             accept;
   logic             timer_xfer;
   logic             slot_ok;
   logic [IDX_W-1:0] slot_idx;
   logic             period_zero;

   logic             rel_we;
   logic [IDX_W-1:0] rel_waddr;
   logic [TW-1:0]    rel_wdata;
   logic             per_we;
   logic [IDX_W-1:0] rd_addr;
   logic [TW-1:0]    rel_rdata;
   logic [TW-1:0]    per_rdata;

   logic [TW-1:0]    rel_sum;
   logic             hit;
   logic             slot_live;
   logic [TW-1:0]    new_rel;

   assign busy       = (state_ff != ptrt_pkg::S_IDLE);
   assign accept     = start && !busy;
   assign opcode     = ptrt_pkg::opcode_type'(req_opcode);
   assign timer_xfer = accept && (opcode == ptrt_pkg::OP_TIMER);
   assign slot_ok    = 32'(req_slot_index) < 32'(TASK_SLOTS);
   assign slot_idx   = req_slot_index[IDX_W-1:0];
   // period * 4 wraps to zero when the low 14 bits are clear
   assign period_zero = (req_period_ticks[TW-3:0] == '0);
   assign rd_addr    = scan_idx_ff[IDX_W-1:0];

   // shared scan unit: one add, one match compare and one minimum compare per slot
   assign rel_sum   = rel_rdata + per_rdata;
   assign slot_live = valid_ff[eval_idx_ff];
   assign hit       = slot_live && (rel_rdata == irq_time_ff);
   assign new_rel   = hit ? rel_sum : rel_rdata;

   ptrt_ram #(.WIDTH(TW), .DEPTH(TASK_SLOTS)) u_release_ram (
      .clock   (clock),
      .wr_en   (rel_we),
      .wr_addr (rel_waddr),
      .wr_data (rel_wdata),
      .rd_addr (rd_addr),
      .rd_data (rel_rdata)
   );

   ptrt_ram #(.WIDTH(TW), .DEPTH(TASK_SLOTS)) u_period_ram (
      .clock   (clock),
      .wr_en   (per_we),
      .wr_addr (slot_idx),
      .wr_data ({req_period_ticks[TW-3:0], 2'b00}),
      .rd_addr (rd_addr),
      .rd_data (per_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      irq_time_in   = irq_time_ff;
      scan_idx_in   = scan_idx_ff;
      eval_vld_in   = eval_vld_ff;
      eval_idx_in   = eval_idx_ff;
      min_in        = min_ff;
      any_in        = any_ff;
      hit_mask_in   = hit_mask_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = ptrt_pkg::STAT_OK;
      rsp_mask_in   = '0;
      rel_we        = 1'b0;
      rel_waddr     = slot_idx;
      rel_wdata     = {req_phase_ticks[TW-3:0], 2'b00};
      per_we        = 1'b0;

      unique case (state_ff)
         ptrt_pkg::S_IDLE: begin
            if (accept) begin
               unique case (opcode)
                  ptrt_pkg::OP_REGISTER: begin
                     rsp_strobe_in = 1'b1;
                     priority if (!slot_ok) begin
                        rsp_status_in = ptrt_pkg::STAT_BOUNDS;
                     end else if (period_zero) begin
                        rsp_status_in = ptrt_pkg::STAT_ZERO_PERIOD;
                     end else if (valid_ff[slot_idx]) begin
                        rsp_status_in = ptrt_pkg::STAT_BUSY;
                     end else begin
                        rel_we             = 1'b1;
                        per_we             = 1'b1;
                        valid_in[slot_idx] = 1'b1;
                     end
                  end
                  ptrt_pkg::OP_UNREGISTER: begin
                     rsp_strobe_in = 1'b1;
                     if (!slot_ok) begin
                        rsp_status_in = ptrt_pkg::STAT_BOUNDS;
                     end else begin
                        valid_in[slot_idx] = 1'b0;
                     end
                  end
                  ptrt_pkg::OP_TIMER: begin
                     state_in    = ptrt_pkg::S_SCAN;
                     scan_idx_in = '0;
                     eval_vld_in = 1'b0;
                     any_in      = 1'b0;
                     hit_mask_in = '0;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ptrt_pkg::S_SCAN: begin
            // read stage runs one slot ahead of the evaluate stage
            if (scan_idx_ff < SLOT_COUNT) begin
               eval_vld_in = 1'b1;
               eval_idx_in = scan_idx_ff[IDX_W-1:0];
               scan_idx_in = scan_idx_ff + 1'b1;
            end else begin
               eval_vld_in = 1'b0;
            end
            if (eval_vld_ff) begin
               if (hit) begin
                  rel_we                   = 1'b1;
                  rel_waddr                = eval_idx_ff;
                  rel_wdata                = rel_sum;
                  hit_mask_in[eval_idx_ff] = 1'b1;
               end
               if (slot_live && (!any_ff || (new_rel < min_ff))) begin
                  min_in = new_rel;
                  any_in = 1'b1;
               end
               if (eval_idx_ff == LAST_IDX) begin
                  state_in      = ptrt_pkg::S_IDLE;
                  eval_vld_in   = 1'b0;
                  irq_time_in   = any_in ? min_in : '0;
                  rsp_strobe_in = 1'b1;
                  rsp_mask_in   = hit_mask_in[7:0];
               end
            end
         end
         default: begin
            state_in = ptrt_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ptrt_pkg::S_IDLE;
         valid_ff      <= '0;
         irq_time_ff   <= '0;
         eval_vld_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         irq_time_ff   <= irq_time_in;
         eval_vld_ff   <= eval_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff   <= scan_idx_in;
      eval_idx_ff   <= eval_idx_in;
      min_ff        <= min_in;
      any_ff        <= any_in;
      hit_mask_ff   <= hit_mask_in;
      rsp_status_ff <= rsp_status_in;
      rsp_mask_ff   <= rsp_mask_in;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_next_interrupt = irq_time_ff;
   assign rsp_released_mask  = rsp_mask_ff;

   `PTRT_ASSERT_NEXT(a_timer_goes_busy, timer_xfer, busy, "timer transfer did not start scan")
   `PTRT_ASSERT_NEXT(a_cmd_responds, accept && !timer_xfer, rsp_strobe_ff, "command result missing")
   `PTRT_ASSERT_SAME(a_rsp_has_source, rsp_strobe_ff, $past(accept) || $past(busy), "spurious result strobe")
   `PTRT_ASSERT_SAME(a_mask_from_scan, rsp_strobe_ff && (rsp_mask_ff != 8'd0), $past(busy), "release mask outside timer match")

endmodule
